// File: rtl/core/dad_pkg.sv
`default_nettype none

package dad_pkg;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [4:0]  DAY_LAST  = 5'd31;
  localparam logic [6:0]  YY_LAST   = 7'd99;

  // Year divided by 100 as a multiply by a reciprocal: exact for all 14-bit years.
  localparam logic [26:0] DIV_MUL   = 27'd5243;
  localparam int          DIV_SHIFT = 19;
  localparam logic [13:0] CENT_MUL  = 14'd100;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [15:0] days_to_add;
  } in_word_t;

  typedef struct packed {
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic        year_overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SPLIT,
    S_WALK,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic split;
    logic step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dad_ctrl.sv
`default_nettype none

module dad_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire dad_pkg::sts_t sts,
  output dad_pkg::cmd_t      cmd
);
  import dad_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = S_PUSH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || out_ready) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DIV))
    else $error("accepted word did not start the year split");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUSH))
    else $error("result raised outside the push state");

endmodule

`default_nettype wire

// File: rtl/core/dad_dp.sv
`default_nettype none

module dad_dp #(
  parameter int ADD_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dad_pkg::cmd_t     cmd,
  input  wire dad_pkg::in_word_t in_word,
  output dad_pkg::sts_t          sts,
  output dad_pkg::out_word_t     out_word
);
  import dad_pkg::*;

  localparam int            DW       = ADD_BITS + 1;
  localparam logic [DW-1:0] ADD_MASK = {1'b0, {ADD_BITS{1'b1}}};

  logic [13:0] y_r;
  logic [3:0]  m_r;
  logic [DW-1:0] d_r;
  logic        ovf_r;
  logic [7:0]  cc_r;
  logic [6:0]  yy_r;
  out_word_t   out_r;

  logic [13:0] y0;
  logic [3:0]  m0;
  logic [4:0]  d0;
  logic [DW-1:0] n0;
  logic [26:0] quot_prod;
  logic [13:0] cent_x100;
  logic        leap;
  logic [4:0]  len;
  logic        walk_done;

  always_comb begin
    y0 = (in_word.start_year == 14'd0) ? 14'd1 : in_word.start_year;
    m0 = in_word.start_month;
    if (m0 == 4'd0) begin
      m0 = MONTH_JAN;
    end else if (m0 > MONTH_DEC) begin
      m0 = MONTH_DEC;
    end
    d0 = (in_word.start_day == 5'd0) ? 5'd1 : in_word.start_day;
    n0 = DW'(in_word.days_to_add) & ADD_MASK;
  end

  assign quot_prod = 27'(y_r) * DIV_MUL;
  assign cent_x100 = 14'(cc_r) * CENT_MUL;

  assign leap      = (yy_r == 7'd0) ? (cc_r[1:0] == 2'd0) : (yy_r[1:0] == 2'd0);
  assign len       = month_days(m_r, leap);
  assign walk_done = ovf_r || (d_r <= DW'(len));
  assign sts.walk_done = walk_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r   <= y0;
      m_r   <= m0;
      d_r   <= DW'(d0) + n0;
      ovf_r <= (y0 > YEAR_MAX);
    end else if (cmd.step) begin
      d_r <= d_r - DW'(len);
      if (m_r == MONTH_DEC) begin
        m_r <= MONTH_JAN;
        if (y_r == YEAR_MAX) begin
          ovf_r <= 1'b1;
        end else begin
          y_r <= y_r + 14'd1;
          if (yy_r == YY_LAST) begin
            yy_r <= 7'd0;
            cc_r <= cc_r + 8'd1;
          end else begin
            yy_r <= yy_r + 7'd1;
          end
        end
      end else begin
        m_r <= m_r + 4'd1;
      end
    end
    if (cmd.div) begin
      cc_r <= quot_prod[DIV_SHIFT+7:DIV_SHIFT];
    end
    if (cmd.split) begin
      yy_r <= 7'(y_r - cent_x100);
    end
    if (cmd.push) begin
      if (ovf_r) begin
        out_r <= '{end_year: YEAR_MAX, end_month: MONTH_DEC, end_day: DAY_LAST,
                   year_overflow: 1'b1};
      end else begin
        out_r <= '{end_year: y_r, end_month: m_r, end_day: d_r[4:0],
                   year_overflow: 1'b0};
      end
    end
  end

  assign out_word = out_r;

  a_day_falls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (d_r < $past(d_r)))
    else $error("day count did not fall on a month step");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (m_r >= MONTH_JAN && m_r <= MONTH_DEC))
    else $error("month out of range while stepping");

endmodule

`default_nettype wire

// File: rtl/core/date_add_days.sv
// Gregorian date plus a count of days.
// The input channel (in_valid, in_ready, in_word) takes one word holding a
// start year, month and day and a day count; only the low ADD_BITS bits of
// the count are used. The result channel (out_valid, out_ready, out_word)
// returns one word per input: the resulting date and an overflow flag, set
// when the year passes 9999, in which case the date reads 9999-12-31.
// After acceptance a word passes the DIV and SPLIT states, which split
// the year into century and year-of-century for the leap rule, then the
// WALK state, where the datapath steps one month per cycle, once for each
// month boundary crossed, and last the PUSH state, which loads the result
// register. One word is in work at a time; in_ready is high only while
// idle, so a new word is accepted only after the last has been pushed.
// A finished result waits in the output register while the next word is
// accepted and worked on; if the receiver still stalls when that word is
// done, the block holds it until the register frees.
// Reset is synchronous and active low; it empties the output register and
// returns the controller to idle.
`default_nettype none

module date_add_days #(
  parameter int ADD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dad_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dad_pkg::out_word_t      out_word
);
  import dad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dad_dp #(
    .ADD_BITS (ADD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
